// File: hw/rtl/tkil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkil_pkg
// Shared types, constants and the byte-to-symbol map for the trie key store.
// ----------------------------------------------------------------------------
package tkil_pkg;

  localparam int NODE_COUNT_DEF    = 4096;
  localparam int ALPHABET_SIZE_DEF = 59;
  localparam int ID_LIMIT_DEF      = 4096;

  localparam int CHAR_W = 8;
  localparam int ID_W   = 12;
  localparam int ST_W   = 3;
  localparam int SYM_W  = 6;

  // result status codes
  localparam logic [ST_W-1:0] ST_WALK     = 3'd0;
  localparam logic [ST_W-1:0] ST_PREFIX   = 3'd1;
  localparam logic [ST_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [ST_W-1:0] ST_MISS     = 3'd3;
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd5;
  localparam logic [ST_W-1:0] ST_BADCHAR  = 3'd6;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHILD,
    S_NODE,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;      // latch item, form child slot
    logic child_rd;  // read child table
    logic node_rd;   // read parent and word id of the child
    logic commit;    // update walk state, tables and result
  } cmd_t;

  typedef struct packed {
    logic out_full;  // result register holds an untaken result
  } stat_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] idx;
  } sym_t;

  // letters fold case to 0..25, punctuation 26..48, digits 49..58
  function automatic sym_t sym_of(input logic [CHAR_W-1:0] b);
    sym_t s;
    s.ok  = 1'b1;
    s.idx = '0;
    if (b >= 8'h61 && b <= 8'h7a) begin
      s.idx = SYM_W'(b - 8'h61);
    end else if (b >= 8'h41 && b <= 8'h5a) begin
      s.idx = SYM_W'(b - 8'h41);
    end else if (b >= 8'h30 && b <= 8'h39) begin
      s.idx = SYM_W'(b - 8'h30 + 8'd49);
    end else begin
      case (b)
        8'h5f: s.idx = 6'd26;  // _
        8'h20: s.idx = 6'd27;  // space
        8'h2d: s.idx = 6'd28;  // -
        8'h2b: s.idx = 6'd29;  // +
        8'h2a: s.idx = 6'd30;  // *
        8'h2f: s.idx = 6'd31;  // /
        8'h7c: s.idx = 6'd32;  // |
        8'h5c: s.idx = 6'd33;  // backslash
        8'h40: s.idx = 6'd34;  // @
        8'h3a: s.idx = 6'd35;  // :
        8'h3f: s.idx = 6'd36;  // ?
        8'h2e: s.idx = 6'd37;  // .
        8'h3d: s.idx = 6'd38;  // =
        8'h25: s.idx = 6'd39;  // %
        8'h23: s.idx = 6'd40;  // #
        8'h3c: s.idx = 6'd41;  // <
        8'h3e: s.idx = 6'd42;  // >
        8'h26: s.idx = 6'd43;  // &
        8'h28: s.idx = 6'd44;  // (
        8'h29: s.idx = 6'd45;  // )
        8'h5b: s.idx = 6'd46;  // [
        8'h5d: s.idx = 6'd47;  // ]
        8'h7e: s.idx = 6'd48;  // ~
        default: s.ok = 1'b0;
      endcase
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/trie_key_insert_lookup.sv
`timescale 1ns / 1ps
// Trie key store: a key arrives one character per transfer, first character
// first, with key_last on its final character; mode selects lookup or insert
// per character and each character gives exactly one result. Every character
// passes through accept, child-table read, parent/word-id read of the child
// and commit, a chain set by the two dependent table reads; its result is
// registered at the commit, and the next character can be accepted once the
// commit is done. A stalled output holds the commit and adds the stall. A new
// character is accepted while the previous result still waits on the output.
// Child links are checked against the parent slot recorded for each allocated
// node, so the block is ready right after reset with no clearing pass.
// ----------------------------------------------------------------------------
// trie_key_insert_lookup
// Top level: sequencer and datapath of the trie key lookup and insert block.
// ----------------------------------------------------------------------------
module trie_key_insert_lookup
  import tkil_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int ID_LIMIT      = ID_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [CHAR_W-1:0] key_char,
  input  logic              key_last,
  input  logic [ID_W-1:0]   entry_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   status,
  output logic [ID_W-1:0]   match_id,
  output logic              result_last
);

  cmd_t  cmd;
  stat_t stat;

  tkil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tkil_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .ID_LIMIT      (ID_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .key_char    (key_char),
    .key_last    (key_last),
    .entry_id    (entry_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .match_id    (match_id),
    .result_last (result_last)
  );

`ifndef SYNTHESIS
  // at most one sequencer command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.child_rd, cmd.node_rd, cmd.commit}))
    else $error("more than one sequencer command active");

  // a commit never overwrites a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("result overwritten before transfer");

  // the table reads always follow an accepted character in order
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> cmd.child_rd ##1 cmd.node_rd)
    else $error("table read sequence broken");

  // only defined status codes are presented
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 3'd7))
    else $error("undefined status code on output");
`endif

endmodule

// File: hw/rtl/tkil_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkil_ctrl
// Sequencer: accept, child read, node read, commit, one character at a time.
// ----------------------------------------------------------------------------
module tkil_ctrl
  import tkil_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_CHILD;
        end
      end
      S_CHILD: begin
        cmd.child_rd = 1'b1;
        state_next   = S_NODE;
      end
      S_NODE: begin
        cmd.node_rd = 1'b1;
        state_next  = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register can take the new result
        if (!stat.out_full) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/tkil_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkil_dp
// Datapath: walk state, node pool, child/parent/word-id tables, result register.
// ----------------------------------------------------------------------------
module tkil_dp
  import tkil_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int ID_LIMIT      = ID_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              mode,
  input  logic [CHAR_W-1:0] key_char,
  input  logic              key_last,
  input  logic [ID_W-1:0]   entry_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ST_W-1:0]   status,
  output logic [ID_W-1:0]   match_id,
  output logic              result_last
);

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SLOT_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);
  localparam logic [ID_W-1:0]   ID_MAX   = ID_W'(ID_LIMIT - 1);
  localparam logic [NODE_W-1:0] USED_MAX = NODE_W'(NODE_COUNT - 1);

  // walk state
  logic              key_dead;
  logic [NODE_W-1:0] walk_node;
  logic [NODE_W-1:0] nodes_used;

  // latched item
  logic              item_mode;
  logic              item_last;
  logic              item_ok;
  logic [ID_W-1:0]   item_id;
  logic [SLOT_W-1:0] slot;

  // table read data
  logic [NODE_W-1:0] child_q;
  logic [SLOT_W-1:0] parent_q;
  logic [ID_W-1:0]   word_q;

  logic [NODE_W-1:0] child_mem  [SLOT_DEPTH];
  logic [SLOT_W-1:0] parent_mem [NODE_COUNT];
  logic [ID_W-1:0]   word_mem   [NODE_COUNT];

  sym_t              sym;
  logic [SLOT_W-1:0] slot_next;
  logic [ID_W-1:0]   id_sat;
  logic              hit;
  logic              full;
  logic [NODE_W-1:0] new_node;
  logic [ST_W-1:0]   res_status;
  logic [ID_W-1:0]   res_match;
  logic [NODE_W-1:0] walk_node_next;
  logic [NODE_W-1:0] nodes_used_next;
  logic              key_dead_next;
  logic              child_we;
  logic              parent_we;
  logic              word_we;
  logic [NODE_W-1:0] word_waddr;
  logic [ID_W-1:0]   word_wdata;

  assign sym       = sym_of(key_char);
  assign slot_next = SLOT_W'(walk_node) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(sym.idx);
  assign id_sat    = ({20'd0, item_id} >= 32'(ID_LIMIT)) ? ID_MAX : item_id;
  assign stat.out_full = out_valid && !out_ready;

  // a child link counts only if its node is allocated and was allocated from
  // this very slot, so the child table needs no clearing after reset
  assign hit      = (child_q != '0) && (child_q <= nodes_used) && (parent_q == slot);
  assign full     = (nodes_used >= USED_MAX);
  assign new_node = nodes_used + NODE_W'(1);

  always_comb begin
    res_status      = ST_WALK;
    res_match       = '0;
    walk_node_next  = walk_node;
    nodes_used_next = nodes_used;
    key_dead_next   = key_dead;
    child_we        = 1'b0;
    parent_we       = 1'b0;
    word_we         = 1'b0;
    word_waddr      = child_q;
    word_wdata      = id_sat;
    if (!item_ok) begin
      res_status    = ST_BADCHAR;
      key_dead_next = 1'b1;
    end else if (key_dead) begin
      res_status    = ST_MISS;
    end else if (item_mode == MODE_LOOKUP) begin
      if (hit) begin
        walk_node_next = child_q;
        res_match      = word_q;
        if (item_last) begin
          res_status = (word_q != '0) ? ST_FOUND : ST_MISS;
        end else if (word_q != '0) begin
          res_status = ST_PREFIX;
        end else begin
          res_match  = '0;
        end
      end else begin
        res_status    = ST_MISS;
        key_dead_next = 1'b1;
      end
    end else begin
      if (hit) begin
        walk_node_next = child_q;
        if (item_last) begin
          word_we    = 1'b1;
          res_status = ST_INSERTED;
          res_match  = id_sat;
        end else begin
          res_match  = word_q;
        end
      end else if (full) begin
        res_status    = ST_FULL;
        key_dead_next = 1'b1;
      end else begin
        // allocate: new node starts with no word unless this is the key end
        nodes_used_next = new_node;
        walk_node_next  = new_node;
        child_we        = 1'b1;
        parent_we       = 1'b1;
        word_we         = 1'b1;
        word_waddr      = new_node;
        word_wdata      = item_last ? id_sat : '0;
        res_status      = item_last ? ST_INSERTED : ST_WALK;
        res_match       = item_last ? id_sat : '0;
      end
    end
    if (item_last) begin
      walk_node_next = '0;
      key_dead_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_node  <= '0;
      nodes_used <= '0;
      key_dead   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.commit) begin
        walk_node  <= walk_node_next;
        nodes_used <= nodes_used_next;
        key_dead   <= key_dead_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode <= mode;
      item_last <= key_last;
      item_ok   <= sym.ok;
      item_id   <= entry_id;
      slot      <= slot_next;
    end
    if (cmd.commit) begin
      status      <= res_status;
      match_id    <= res_match;
      result_last <= item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.child_rd) begin
      child_q <= child_mem[slot];
    end
    if (cmd.commit && child_we) begin
      child_mem[slot] <= new_node;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_rd) begin
      parent_q <= parent_mem[child_q];
    end
    if (cmd.commit && parent_we) begin
      parent_mem[new_node] <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_rd) begin
      word_q <= word_mem[child_q];
    end
    if (cmd.commit && word_we) begin
      word_mem[word_waddr] <= word_wdata;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the trie key lookup and insert block character by character. A
// scoreboard keeps its own copy of the trie (child links, word ids, pool
// count, walk position) and predicts one result per accepted character;
// results are compared in order. Stimulus: a directed part, then random keys
// with shared prefixes under four idling phases.
// ----------------------------------------------------------------------------
module testbench;
  import tkil_pkg::*;

  localparam int WORD_SLOTS = 128;
  localparam int KEY_MAX    = 64;

  class trie_result_board;
    typedef struct {
      logic [ST_W-1:0] status;
      logic [ID_W-1:0] id;
      logic            last;
    } result_t;

    result_t         pending[$];
    int              links[int];
    logic [ID_W-1:0] word_ids[NODE_COUNT_DEF];
    int              pool_used;
    int              walk_pos;
    bit              key_dead;
    int              errors;

    function new();
      foreach (word_ids[i]) word_ids[i] = '0;
      pool_used = 0;
      walk_pos  = 0;
      key_dead  = 1'b0;
      errors    = 0;
    endfunction

    // -1 for a byte outside the alphabet
    function int symbol_index(logic [CHAR_W-1:0] b);
      string marks;
      marks = "_ -+*/|\\@:?.=%#<>&()[]~";
      if (b >= "a" && b <= "z") return int'(b - "a");
      if (b >= "A" && b <= "Z") return int'(b - "A");
      if (b >= "0" && b <= "9") return int'(b - "0") + 49;
      for (int i = 0; i < marks.len(); i++) begin
        if (marks[i] == b) return 26 + i;
      end
      return -1;
    endfunction

    function void note_char(logic m, logic [CHAR_W-1:0] ch, logic last,
                            logic [ID_W-1:0] eid);
      result_t r;
      int      sym;
      int      slot;
      int      nxt;
      int      v;
      sym      = symbol_index(ch);
      r.status = ST_WALK;
      r.id     = '0;
      r.last   = last;
      if (sym < 0) begin
        r.status = ST_BADCHAR;
        key_dead = 1'b1;
      end else if (key_dead || walk_pos >= NODE_COUNT_DEF) begin
        r.status = ST_MISS;
        key_dead = 1'b1;
      end else begin
        slot = walk_pos * ALPHABET_SIZE_DEF + sym;
        nxt  = links.exists(slot) ? links[slot] : 0;
        if (m == MODE_LOOKUP) begin
          if (nxt == 0) begin
            r.status = ST_MISS;
            key_dead = 1'b1;
          end else begin
            walk_pos = nxt;
            if (last) begin
              r.status = (word_ids[nxt] != 0) ? ST_FOUND : ST_MISS;
              r.id     = word_ids[nxt];
            end else if (word_ids[nxt] != 0) begin
              r.status = ST_PREFIX;
              r.id     = word_ids[nxt];
            end
          end
        end else begin
          if (nxt == 0) begin
            if (pool_used + 1 >= NODE_COUNT_DEF) begin
              r.status = ST_FULL;
              key_dead = 1'b1;
            end else begin
              pool_used++;
              nxt = pool_used;
              links[slot] = nxt;
            end
          end
          if (!key_dead) begin
            walk_pos = nxt;
            if (last) begin
              v = int'(eid);
              if (v >= ID_LIMIT_DEF) v = ID_LIMIT_DEF - 1;
              word_ids[nxt] = ID_W'(v);
              r.status      = ST_INSERTED;
              r.id          = ID_W'(v);
            end else begin
              r.id = word_ids[nxt];
            end
          end
        end
      end
      if (last) begin
        walk_pos = 0;
        key_dead = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [ST_W-1:0] st, logic [ID_W-1:0] id, logic last);
      result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d match_id %0d result_last %0b",
                 $time, st, id, last);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
      end
      if (id !== e.id) begin
        errors++;
        $display("%0t: match_id mismatch: expected %0d actual %0d", $time, e.id, id);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: result_last mismatch: expected %0b actual %0b", $time, e.last, last);
      end
    endfunction
  endclass

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              mode     = MODE_LOOKUP;
  logic [CHAR_W-1:0] key_char = '0;
  logic              key_last = 1'b0;
  logic [ID_W-1:0]   entry_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ST_W-1:0]   status;
  logic [ID_W-1:0]   match_id;
  logic              result_last;

  trie_result_board board = new();

  int send_idle  = 0;
  int recv_stall = 0;
  int items_sent = 0;

  // key being sent, one mode per character
  logic [CHAR_W-1:0] kbuf[KEY_MAX];
  logic              kmode[KEY_MAX];
  int                klen = 0;

  // words inserted so far, looked up again later
  logic [CHAR_W-1:0] word_chars[WORD_SLOTS][KEY_MAX];
  int                word_len[WORD_SLOTS];
  int                word_cnt = 0;

  string narrow_set = "abc01_-";
  string full_set   = "abcdefghijklmnopqrstuvwxyz_ -+*/|\\@:?.=%#<>&()[]~0123456789";

  trie_key_insert_lookup u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .key_char    (key_char),
    .key_last    (key_last),
    .entry_id    (entry_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .match_id    (match_id),
    .result_last (result_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result(status, match_id, result_last);
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if ($urandom_range(1) == 1 && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic void load_text(input string s, input logic m);
    klen = s.len();
    for (int i = 0; i < klen; i++) begin
      kbuf[i]  = s[i];
      kmode[i] = m;
    end
  endfunction

  function automatic void make_word(input int len, input bit narrow, input logic m);
    string set;
    set  = narrow ? narrow_set : full_set;
    klen = len;
    for (int i = 0; i < len; i++) begin
      kbuf[i]  = fold_case(set[$urandom_range(set.len() - 1)]);
      kmode[i] = m;
    end
  endfunction

  function automatic void load_word(input int idx);
    klen = word_len[idx];
    for (int i = 0; i < klen; i++) begin
      kbuf[i]  = fold_case(word_chars[idx][i]);
      kmode[i] = MODE_LOOKUP;
    end
  endfunction

  task automatic send_key(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] eid;
    logic            last;
    for (int i = 0; i < klen; i++) begin
      last = (i == klen - 1);
      eid  = last ? id : ID_W'($urandom_range(4095));
      while ($urandom_range(99) < send_idle) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      mode     <= kmode[i];
      key_char <= kbuf[i];
      key_last <= last;
      entry_id <= eid;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      board.note_char(kmode[i], kbuf[i], last, eid);
      items_sent++;
    end
  endtask

  initial begin
    int target;
    int pick;
    int slot;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 54; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 54; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase

      if (p == 0) begin
        load_text("a", MODE_LOOKUP);     send_key('0);  // empty trie
        load_text("Ab", MODE_INSERT);    send_key(12'hfff);
        load_text("aB", MODE_LOOKUP);    send_key('0);  // case folded hit
        load_text("abc", MODE_LOOKUP);   send_key('0);  // prefix word, then miss
        load_text("~9", MODE_INSERT);    send_key(12'h800);
        load_text("~9", MODE_LOOKUP);    send_key('0);
        // bad byte in the middle, rest of the key dead
        load_text("a?b", MODE_LOOKUP);   kbuf[1] = 8'h00; send_key('0);
        load_text("z?", MODE_INSERT);    kbuf[1] = 8'hff; send_key(12'h001);
        // bad byte on an already dead key
        load_text("q?", MODE_LOOKUP);    kbuf[1] = 8'h80; send_key('0);
        // dead key continues in insert mode
        load_text("qr", MODE_LOOKUP);    kmode[1] = MODE_INSERT; send_key(12'h123);
        // zero id removes the word
        load_text("ab", MODE_INSERT);    send_key('0);
        load_text("AB", MODE_LOOKUP);    send_key('0);
        // mode change within a key
        load_text("xy", MODE_INSERT);    kmode[1] = MODE_LOOKUP; send_key('0);
        load_text("x", MODE_LOOKUP);     send_key('0);
      end

      target = items_sent + 300;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          make_word($urandom_range(1, 6), 1'b1, MODE_INSERT);
          if (word_cnt < WORD_SLOTS) begin
            slot = word_cnt;
            word_cnt = word_cnt + 1;
          end else begin
            slot = $urandom_range(WORD_SLOTS - 1);
          end
          word_len[slot] = klen;
          for (int i = 0; i < klen; i++) word_chars[slot][i] = kbuf[i];
          send_key((pick < 3) ? '0 : ID_W'($urandom_range(4095)));
        end else if (pick < 75) begin
          if (word_cnt > 0 && $urandom_range(9) < 7) load_word($urandom_range(word_cnt - 1));
          else make_word($urandom_range(1, 6), 1'b1, MODE_LOOKUP);
          if (klen > 1 && $urandom_range(3) == 0) klen--;
          send_key(ID_W'($urandom_range(4095)));
        end else if (pick < 85) begin
          // noise: raw bytes, mixed modes
          klen = $urandom_range(1, 4);
          for (int i = 0; i < klen; i++) begin
            kbuf[i]  = CHAR_W'($urandom_range(255));
            kmode[i] = 1'($urandom_range(1));
          end
          send_key(ID_W'($urandom_range(4095)));
        end else begin
          // well-formed key with one damaged character or a mode flip
          if (word_cnt > 0) load_word($urandom_range(word_cnt - 1));
          else make_word($urandom_range(1, 6), 1'b1, MODE_LOOKUP);
          slot = $urandom_range(klen - 1);
          if ($urandom_range(1) == 1) kbuf[slot] = CHAR_W'($urandom_range(255));
          else kmode[slot] = ~kmode[slot];
          send_key(ID_W'($urandom_range(4095)));
        end
      end
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
